// ----- src/cdir_pkg.sv -----
`default_nettype none

package cdir_pkg;

    localparam int NODES   = 16;
    localparam int NODE_W  = 4;
    localparam int ENTRIES = 1024;
    localparam int IDX_W   = 10;

    localparam logic [NODE_W-1:0] SELF_NODE_RST = NODE_W'(1);

    // register index, taken from paddr[2]
    localparam logic REG_SELF_NODE = 1'b0;

    typedef enum logic [1:0] {
        OP_ADD_SHARE       = 2'd0,
        OP_OWNER_TO_SHARER = 2'd1,
        OP_ERASE_SHARE     = 2'd2,
        OP_FETCH           = 2'd3
    } t_op;

    typedef struct packed {
        logic              owner_valid;
        logic [NODE_W-1:0] owner_node;
        logic [NODES-1:0]  sharers;
    } t_entry;

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] node;
        logic              is_self;
    } t_target;

endpackage

`default_nettype wire

// ----- src/cdir_update.sv -----
`default_nettype none

// Entry update and fetch target selection for one directory entry.
module cdir_update
    import cdir_pkg::*;
(
    input  var t_op               i_op,
    input  var logic [NODE_W-1:0] i_node,
    input  var logic [NODE_W-1:0] i_self_node,
    input  var t_entry            i_entry,
    output t_entry                o_entry,
    output t_target               o_target
);

    logic [NODE_W-1:0] w_low_sharer;
    logic              w_owner_match;

    assign w_owner_match = i_entry.owner_valid && (i_entry.owner_node == i_node);

    // lowest set sharer bit
    always_comb begin
        w_low_sharer = '0;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (i_entry.sharers[i]) begin
                w_low_sharer = NODE_W'(i);
            end
        end
    end

    always_comb begin
        o_entry  = i_entry;
        o_target = '0;
        case (i_op)
            OP_ADD_SHARE: begin
                if (!i_entry.owner_valid || w_owner_match) begin
                    o_entry.owner_valid = 1'b1;
                    o_entry.owner_node  = i_node;
                end else begin
                    o_entry.sharers[i_node] = 1'b1;
                end
            end
            OP_OWNER_TO_SHARER: begin
                o_entry.owner_valid     = 1'b0;
                o_entry.owner_node      = '0;
                o_entry.sharers[i_node] = 1'b1;
            end
            OP_ERASE_SHARE: begin
                if (w_owner_match) begin
                    o_entry.owner_valid = 1'b0;
                    o_entry.owner_node  = '0;
                end else begin
                    o_entry.sharers[i_node] = 1'b0;
                end
            end
            OP_FETCH: begin
                if (i_entry.owner_valid) begin
                    o_target.valid = 1'b1;
                    o_target.node  = i_entry.owner_node;
                end else if (i_entry.sharers != '0) begin
                    o_target.valid = 1'b1;
                    o_target.node  = w_low_sharer;
                end
                o_target.is_self = o_target.valid && (o_target.node == i_self_node);
            end
            default: begin
                o_entry  = i_entry;
                o_target = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/coherence_directory_entry_update.sv -----
`default_nettype none

// Full-map coherence directory: 1024 entries, each an optional owner node and a
// 16-bit sharer mask. Every item does one read-modify-write of the entry picked
// by block_index and returns one result: the entry after the operation and, for
// a fetch, the node to forward to (owner first, else lowest sharer). Throughput
// is one item per cycle while the result is not stalled. An accepted item reads
// its entry as it enters the update stage; when that stage advances, the updated
// entry is written back and the result is loaded into the output register. A
// stalled result holds the item behind it in the update stage, and the input
// stalls until that item moves. Back-to-back items to the same entry are handled
// by a one-deep bypass of the write that lands in the same cycle as the next
// read. After reset the entry memory is cleared one entry per cycle, during which
// the input is stalled; self_node writes on the APB port are taken at any time.
module coherence_directory_entry_update
    import cdir_pkg::*;
(
    input  var logic              i_clk,
    input  var logic              i_rst_n,

    // config port
    input  var logic              psel,
    input  var logic              penable,
    input  var logic              pwrite,
    input  var logic [2:0]        paddr,
    input  var logic [31:0]       pwdata,
    output logic     [31:0]       prdata,
    output logic                  pready,

    // input items
    input  var logic              i_in_valid,
    output logic                  o_in_stall,
    input  var logic [1:0]        i_operation,
    input  var logic [IDX_W-1:0]  i_block_index,
    input  var logic [NODE_W-1:0] i_node_id,

    // result items
    output logic                  o_out_valid,
    input  var logic              i_out_stall,
    output logic                  o_owner_valid,
    output logic [NODE_W-1:0]     o_owner_node,
    output logic [NODES-1:0]      o_sharer_mask,
    output logic                  o_target_valid,
    output logic [NODE_W-1:0]     o_target_node,
    output logic                  o_target_is_self
);

    // ---------------------------------------------------------------
    // config register
    // ---------------------------------------------------------------
    logic [NODE_W-1:0] r_self_node;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_node <= SELF_NODE_RST;
        end else if (w_cfg_wr && (paddr[2] == REG_SELF_NODE)) begin
            r_self_node <= pwdata[NODE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_SELF_NODE) ? 32'(r_self_node) : 32'd0;

    // ---------------------------------------------------------------
    // clearing pass after reset
    // ---------------------------------------------------------------
    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + IDX_W'(1);
            if (r_clr_addr == IDX_W'(ENTRIES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // pipeline control
    // ---------------------------------------------------------------
    logic             r_s1_valid;
    t_op              r_s1_op;
    logic [IDX_W-1:0] r_s1_idx;
    logic [NODE_W-1:0] r_s1_node;
    logic             r_out_valid;

    logic w_in_acc;
    logic w_s1_adv;

    assign w_s1_adv   = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_clr_busy || (r_s1_valid && !w_s1_adv);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_op   <= t_op'(i_operation);
            r_s1_idx  <= i_block_index;
            r_s1_node <= i_node_id;
        end
    end

    // ---------------------------------------------------------------
    // entry memory, one write and one registered read port
    // ---------------------------------------------------------------
    t_entry           r_mem [ENTRIES];
    t_entry           r_rd_data;
    t_entry           w_next_entry;
    t_target          w_target;
    logic             w_mem_we;
    logic [IDX_W-1:0] w_mem_waddr;
    t_entry           w_mem_wdata;

    assign w_mem_we    = r_clr_busy || w_s1_adv;
    assign w_mem_waddr = r_clr_busy ? r_clr_addr : r_s1_idx;
    assign w_mem_wdata = r_clr_busy ? t_entry'('0) : w_next_entry;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_rd_data <= r_mem[i_block_index];
        end
    end

    // Bypass: the read for a new item returns pre-write data when the item
    // ahead writes back at the same edge. Capture that write.
    logic             r_byp_valid;
    logic [IDX_W-1:0] r_byp_idx;
    t_entry           r_byp_data;
    t_entry           w_cur_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_byp_valid <= w_s1_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_byp_idx  <= r_s1_idx;
            r_byp_data <= w_next_entry;
        end
    end

    assign w_cur_entry = (r_byp_valid && (r_byp_idx == r_s1_idx)) ? r_byp_data : r_rd_data;

    cdir_update u_update (
        .i_op        (r_s1_op),
        .i_node      (r_s1_node),
        .i_self_node (r_self_node),
        .i_entry     (w_cur_entry),
        .o_entry     (w_next_entry),
        .o_target    (w_target)
    );

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    t_entry  r_out_entry;
    t_target r_out_target;

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_entry  <= w_next_entry;
            r_out_target <= w_target;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_owner_valid    = r_out_entry.owner_valid;
    assign o_owner_node     = r_out_entry.owner_valid ? r_out_entry.owner_node : '0;
    assign o_sharer_mask    = r_out_entry.sharers;
    assign o_target_valid   = r_out_target.valid;
    assign o_target_node    = r_out_target.node;
    assign o_target_is_self = r_out_target.is_self;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> o_in_stall)
        else $error("item accepted during clearing pass");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_s1_valid)
        else $error("accepted item lost before update stage");

    a_self_needs_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_target_is_self) |-> o_target_valid)
        else $error("target_is_self without a target");

    a_target_only_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && (r_s1_op != OP_FETCH)) |-> !w_target.valid)
        else $error("target reported for non-fetch operation");

endmodule

`default_nettype wire
